### src/rgb2hsv_pkg.sv
// shared constants and types for the rgb to hsv pixel converter
// no dependencies; compiled first
`default_nettype none

package rgb2hsv_pkg;

   // fraction bits of every channel, one equals 2**FRAC_BITS_DEF
   localparam int unsigned FRAC_BITS_DEF = 12;

   // special cases that ride along the divider pipeline
   typedef struct packed {
      logic sat_zero;  // black pixel, saturation forced to zero
      logic sat_one;   // smallest channel is zero, saturation is exactly one
      logic hue_zero;  // gray pixel, hue forced to zero
      logic hue_neg;   // red sector with green below blue, hue wraps
   } flag_type;

endpackage

`default_nettype wire

### src/rgb2hsv_if.sv
// valid/ready channel interfaces for pixel transactions in and out
// depends on rgb2hsv_pkg for the default fraction width
`default_nettype none

interface rgb2hsv_req_if #(
   parameter int unsigned FRAC_BITS = rgb2hsv_pkg::FRAC_BITS_DEF
);
   logic                 valid;
   logic                 ready;
   logic [FRAC_BITS:0]   red_in;
   logic [FRAC_BITS:0]   green_in;
   logic [FRAC_BITS:0]   blue_in;

   modport source (output valid, output red_in, output green_in, output blue_in,
                   input ready);
   modport sink   (input valid, input red_in, input green_in, input blue_in,
                   output ready);
endinterface

interface rgb2hsv_rsp_if #(
   parameter int unsigned FRAC_BITS = rgb2hsv_pkg::FRAC_BITS_DEF
);
   logic                 valid;
   logic                 ready;
   logic [FRAC_BITS-1:0] hue_out;
   logic [FRAC_BITS:0]   sat_out;
   logic [FRAC_BITS:0]   val_out;

   modport source (output valid, output hue_out, output sat_out, output val_out,
                   input ready);
   modport sink   (input valid, input hue_out, input sat_out, input val_out,
                   output ready);
endinterface

`default_nettype wire

### src/rgb2hsv_front.sv
// first two pipeline stages: clamp, max/min and sector, then chroma,
// hue numerator and divider setup; depends on rgb2hsv_pkg
`default_nettype none

module rgb2hsv_front #(
   parameter int unsigned FRAC_BITS = rgb2hsv_pkg::FRAC_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output      logic                   in_ready,
   input  wire logic [FRAC_BITS:0]     red,
   input  wire logic [FRAC_BITS:0]     green,
   input  wire logic [FRAC_BITS:0]     blue,
   output      logic                   out_valid,
   input  wire logic                   out_ready,
   output      logic [FRAC_BITS:0]     rem_s,
   output      logic [FRAC_BITS:0]     div_v,
   output      logic [FRAC_BITS+2:0]   rem_h,
   output      logic [FRAC_BITS+2:0]   div_h,
   output      rgb2hsv_pkg::flag_type  flags
);
   import rgb2hsv_pkg::*;

   localparam int unsigned W  = FRAC_BITS + 1;
   localparam int unsigned HW = FRAC_BITS + 3;
   localparam logic [W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   typedef enum logic [1:0] {SEC_RED, SEC_GREEN, SEC_BLUE} sector_type;

   // stage 1 registers
   logic          valid1_ff;
   logic [W-1:0]  r1_ff, g1_ff, b1_ff, v1_ff, mn1_ff;
   logic [W-1:0]  r1_in, g1_in, b1_in, v1_in, mn1_in;
   sector_type    sec1_ff, sec1_in;
   logic          ready1;

   // stage 2 registers
   logic          valid2_ff;
   logic [W-1:0]  rs2_ff, dv2_ff, rs2_in, dv2_in;
   logic [HW-1:0] rh2_ff, dh2_ff, rh2_in, dh2_in;
   flag_type      flag2_ff, flag2_in;
   logic          ready2;

   logic [W-1:0]  max_rg, min_rg;
   logic [W-1:0]  chroma;
   logic [HW-1:0] chroma_x;
   logic          red_neg;

   assign ready2   = !valid2_ff || out_ready;
   assign ready1   = !valid1_ff || ready2;
   assign in_ready = ready1;

   // stage 1: clamp inputs above one, find extremes and the winning channel
   always_comb begin
      r1_in  = (red   > ONE) ? ONE : red;
      g1_in  = (green > ONE) ? ONE : green;
      b1_in  = (blue  > ONE) ? ONE : blue;
      max_rg = (r1_in >= g1_in) ? r1_in : g1_in;
      min_rg = (r1_in <= g1_in) ? r1_in : g1_in;
      v1_in  = (max_rg >= b1_in) ? max_rg : b1_in;
      mn1_in = (min_rg <= b1_in) ? min_rg : b1_in;
      // ties go to red first, then green
      if (v1_in == r1_in) begin
         sec1_in = SEC_RED;
      end else if (v1_in == g1_in) begin
         sec1_in = SEC_GREEN;
      end else begin
         sec1_in = SEC_BLUE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else if (ready1) begin
         valid1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1 && in_valid) begin
         r1_ff   <= r1_in;
         g1_ff   <= g1_in;
         b1_ff   <= b1_in;
         v1_ff   <= v1_in;
         mn1_ff  <= mn1_in;
         sec1_ff <= sec1_in;
      end
   end

   // stage 2: chroma, magnitude of the hue numerator and the divisors
   always_comb begin
      chroma   = v1_ff - mn1_ff;
      chroma_x = HW'(chroma);
      red_neg  = 1'b0;
      case (sec1_ff)
         SEC_RED: begin
            red_neg = g1_ff < b1_ff;
            rh2_in  = red_neg ? HW'(b1_ff - g1_ff) : HW'(g1_ff - b1_ff);
         end
         SEC_GREEN: begin
            // b - r stays above -chroma, so the sum is never negative
            rh2_in = (chroma_x << 1) + HW'(b1_ff) - HW'(r1_ff);
         end
         SEC_BLUE: begin
            rh2_in = (chroma_x << 2) + HW'(r1_ff) - HW'(g1_ff);
         end
         default: begin
            rh2_in = '0;
         end
      endcase
      dh2_in            = (chroma_x << 2) + (chroma_x << 1);
      flag2_in.sat_zero = (v1_ff == '0);
      flag2_in.sat_one  = (mn1_ff == '0) && (v1_ff != '0);
      flag2_in.hue_zero = (chroma == '0);
      flag2_in.hue_neg  = red_neg;
      // chroma equal to value takes the integer quotient bit here
      rs2_in            = flag2_in.sat_one ? '0 : chroma;
      dv2_in            = v1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else if (ready2) begin
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready2 && valid1_ff) begin
         rs2_ff   <= rs2_in;
         dv2_ff   <= dv2_in;
         rh2_ff   <= rh2_in;
         dh2_ff   <= dh2_in;
         flag2_ff <= flag2_in;
      end
   end

   assign out_valid = valid2_ff;
   assign rem_s     = rs2_ff;
   assign div_v     = dv2_ff;
   assign rem_h     = rh2_ff;
   assign div_h     = dh2_ff;
   assign flags     = flag2_ff;

endmodule

`default_nettype wire

### src/rgb2hsv_div_stage.sv
// one restoring-division stage: a quotient bit for saturation and one for hue
// depends on rgb2hsv_pkg for the flag struct
`default_nettype none

module rgb2hsv_div_stage #(
   parameter int unsigned FRAC_BITS = rgb2hsv_pkg::FRAC_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output      logic                     in_ready,
   input  wire logic [FRAC_BITS:0]       in_rem_s,
   input  wire logic [FRAC_BITS:0]       in_div_v,
   input  wire logic [FRAC_BITS-1:0]     in_q_s,
   input  wire logic [FRAC_BITS+2:0]     in_rem_h,
   input  wire logic [FRAC_BITS+2:0]     in_div_h,
   input  wire logic [FRAC_BITS-1:0]     in_q_h,
   input  wire rgb2hsv_pkg::flag_type    in_flags,
   output      logic                     out_valid,
   input  wire logic                     out_ready,
   output      logic [FRAC_BITS:0]       out_rem_s,
   output      logic [FRAC_BITS:0]       out_div_v,
   output      logic [FRAC_BITS-1:0]     out_q_s,
   output      logic [FRAC_BITS+2:0]     out_rem_h,
   output      logic [FRAC_BITS+2:0]     out_div_h,
   output      logic [FRAC_BITS-1:0]     out_q_h,
   output      rgb2hsv_pkg::flag_type    out_flags
);
   import rgb2hsv_pkg::*;

   localparam int unsigned W  = FRAC_BITS + 1;
   localparam int unsigned HW = FRAC_BITS + 3;

   logic              valid_ff;
   logic [W-1:0]      rem_s_ff, rem_s_in, div_v_ff;
   logic [HW-1:0]     rem_h_ff, rem_h_in, div_h_ff;
   logic [FRAC_BITS-1:0] q_s_ff, q_s_in, q_h_ff, q_h_in;
   flag_type          flags_ff;

   logic [W:0]        dbl_s, sub_s;
   logic [HW:0]       dbl_h, sub_h;
   logic              bit_s, bit_h;

   assign in_ready = !valid_ff || out_ready;

   // remainders stay below their divisors, so the doubled value fits one more bit
   always_comb begin
      dbl_s    = {in_rem_s, 1'b0};
      sub_s    = dbl_s - {1'b0, in_div_v};
      bit_s    = dbl_s >= {1'b0, in_div_v};
      rem_s_in = bit_s ? sub_s[W-1:0] : dbl_s[W-1:0];
      q_s_in   = {in_q_s[FRAC_BITS-2:0], bit_s};

      dbl_h    = {in_rem_h, 1'b0};
      sub_h    = dbl_h - {1'b0, in_div_h};
      bit_h    = dbl_h >= {1'b0, in_div_h};
      rem_h_in = bit_h ? sub_h[HW-1:0] : dbl_h[HW-1:0];
      q_h_in   = {in_q_h[FRAC_BITS-2:0], bit_h};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         rem_s_ff <= rem_s_in;
         div_v_ff <= in_div_v;
         q_s_ff   <= q_s_in;
         rem_h_ff <= rem_h_in;
         div_h_ff <= in_div_h;
         q_h_ff   <= q_h_in;
         flags_ff <= in_flags;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem_s = rem_s_ff;
   assign out_div_v = div_v_ff;
   assign out_q_s   = q_s_ff;
   assign out_rem_h = rem_h_ff;
   assign out_div_h = div_h_ff;
   assign out_q_h   = q_h_ff;
   assign out_flags = flags_ff;

endmodule

`default_nettype wire

### src/rgb2hsv_back.sv
// output stage: applies special cases and hue wrap, holds the result register
// depends on rgb2hsv_pkg for the flag struct
`default_nettype none

module rgb2hsv_back #(
   parameter int unsigned FRAC_BITS = rgb2hsv_pkg::FRAC_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output      logic                   in_ready,
   input  wire logic [FRAC_BITS:0]     in_val,
   input  wire logic [FRAC_BITS-1:0]   in_q_s,
   input  wire logic [FRAC_BITS-1:0]   in_q_h,
   input  wire rgb2hsv_pkg::flag_type  in_flags,
   output      logic                   out_valid,
   input  wire logic                   out_ready,
   output      logic [FRAC_BITS-1:0]   hue,
   output      logic [FRAC_BITS:0]     sat,
   output      logic [FRAC_BITS:0]     val
);
   import rgb2hsv_pkg::*;

   localparam int unsigned W = FRAC_BITS + 1;
   localparam logic [W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   logic                 valid_ff;
   logic [FRAC_BITS-1:0] hue_ff, hue_in;
   logic [W-1:0]         sat_ff, sat_in, val_ff;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      if (in_flags.sat_zero) begin
         sat_in = '0;
      end else if (in_flags.sat_one) begin
         sat_in = ONE;
      end else begin
         sat_in = {1'b0, in_q_s};
      end
      // negative quotient gets one turn added; a zero quotient stays zero
      if (in_flags.hue_zero) begin
         hue_in = '0;
      end else if (in_flags.hue_neg) begin
         hue_in = '0 - in_q_h;
      end else begin
         hue_in = in_q_h;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         hue_ff <= hue_in;
         sat_ff <= sat_in;
         val_ff <= in_val;
      end
   end

   assign out_valid = valid_ff;
   assign hue       = hue_ff;
   assign sat       = sat_ff;
   assign val       = val_ff;

endmodule

`default_nettype wire

### src/rgb_to_hsv_pixel_converter_top.sv
// top level of the rgb to hsv pixel converter: front stages, divider chain, output stage
// depends on rgb2hsv_pkg, rgb2hsv_if, rgb2hsv_front, rgb2hsv_div_stage, rgb2hsv_back
//
//   port     dir  transaction                       payload
//   req_if   in   one pixel, rgb                    red_in, green_in, blue_in
//   rsp_if   out  one pixel, hsv                    hue_out, sat_out, val_out
//
// a pixel is accepted every cycle unless back-pressure from the output has filled the pipeline
// the two dividers resolve one quotient bit per stage
// reset clears the valid bit of every stage; payload registers are not reset
// each stage holds while its successor is full and stalled, empty stages keep filling,
// so input is taken while a finished result still waits at the output
`default_nettype none

module rgb_to_hsv_pixel_converter_top #(
   parameter int unsigned FRAC_BITS = rgb2hsv_pkg::FRAC_BITS_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   rgb2hsv_req_if.sink   req_if,
   rgb2hsv_rsp_if.source rsp_if
);
   import rgb2hsv_pkg::*;

   localparam int unsigned W  = FRAC_BITS + 1;
   localparam int unsigned HW = FRAC_BITS + 3;
   localparam logic [W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   // index k feeds divider stage k, index FRAC_BITS feeds the output stage
   logic                 valid_q [0:FRAC_BITS];
   logic                 ready_q [0:FRAC_BITS];
   logic [W-1:0]         rem_s_q [0:FRAC_BITS];
   logic [W-1:0]         div_v_q [0:FRAC_BITS];
   logic [FRAC_BITS-1:0] q_s_q   [0:FRAC_BITS];
   logic [HW-1:0]        rem_h_q [0:FRAC_BITS];
   logic [HW-1:0]        div_h_q [0:FRAC_BITS];
   logic [FRAC_BITS-1:0] q_h_q   [0:FRAC_BITS];
   flag_type             flags_q [0:FRAC_BITS];

   rgb2hsv_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .in_ready  (req_if.ready),
      .red       (req_if.red_in),
      .green     (req_if.green_in),
      .blue      (req_if.blue_in),
      .out_valid (valid_q[0]),
      .out_ready (ready_q[0]),
      .rem_s     (rem_s_q[0]),
      .div_v     (div_v_q[0]),
      .rem_h     (rem_h_q[0]),
      .div_h     (div_h_q[0]),
      .flags     (flags_q[0])
   );

   assign q_s_q[0] = '0;
   assign q_h_q[0] = '0;

   for (genvar k = 0; k < FRAC_BITS; k++) begin : g_div
      rgb2hsv_div_stage #(.FRAC_BITS(FRAC_BITS)) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_q[k]),
         .in_ready  (ready_q[k]),
         .in_rem_s  (rem_s_q[k]),
         .in_div_v  (div_v_q[k]),
         .in_q_s    (q_s_q[k]),
         .in_rem_h  (rem_h_q[k]),
         .in_div_h  (div_h_q[k]),
         .in_q_h    (q_h_q[k]),
         .in_flags  (flags_q[k]),
         .out_valid (valid_q[k+1]),
         .out_ready (ready_q[k+1]),
         .out_rem_s (rem_s_q[k+1]),
         .out_div_v (div_v_q[k+1]),
         .out_q_s   (q_s_q[k+1]),
         .out_rem_h (rem_h_q[k+1]),
         .out_div_h (div_h_q[k+1]),
         .out_q_h   (q_h_q[k+1]),
         .out_flags (flags_q[k+1])
      );
   end

   rgb2hsv_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_q[FRAC_BITS]),
      .in_ready  (ready_q[FRAC_BITS]),
      .in_val    (div_v_q[FRAC_BITS]),
      .in_q_s    (q_s_q[FRAC_BITS]),
      .in_q_h    (q_h_q[FRAC_BITS]),
      .in_flags  (flags_q[FRAC_BITS]),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .hue       (rsp_if.hue_out),
      .sat       (rsp_if.sat_out),
      .val       (rsp_if.val_out)
   );

   // saturation and value never exceed one
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.sat_out <= ONE) && (rsp_if.val_out <= ONE))
      else $error("hsv result above one");

   // black pixel carries no saturation and no hue
   a_black: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && (rsp_if.val_out == '0) |->
         (rsp_if.sat_out == '0) && (rsp_if.hue_out == '0))
      else $error("black pixel with nonzero saturation or hue");

   // zero saturation means zero chroma, so hue must be zero too
   a_gray: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && (rsp_if.sat_out == '0) |-> (rsp_if.hue_out == '0))
      else $error("gray pixel with nonzero hue");

   // the last divider stage, when full and not drained, must keep its transaction
   a_hold: assert property (@(posedge clock) disable iff (reset)
      valid_q[FRAC_BITS] && !ready_q[FRAC_BITS] |=> valid_q[FRAC_BITS])
      else $error("last divider stage dropped a transaction");

endmodule

`default_nettype wire
